FILE: hdl/matrix_inverse_3x3_macros.svh
// Assertion macros for the matrix inverse top module.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Check that holds in the same cycle as its trigger.
`define MI3_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that holds in the cycle after its trigger.
`define MI3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/mi3_pkg.sv
// Constants and index tables for the 3x3 matrix inverse pipeline.
package mi3_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int N_ENT = 9;

    // Cofactor k of the adjugate is m[A]*m[D] - m[B]*m[C], row-major indexes.
    localparam int CF_A [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CF_D [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CF_B [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CF_C [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // The determinant expands along row 0 against adjugate entries 0, 3 and 6.
    localparam int DET_ADJ [3] = '{0, 3, 6};

endpackage

FILE: hdl/mi3_div_stage.sv
// One restoring-division stage: resolves quotient bit K for all nine entries.
module mi3_div_stage
    import mi3_pkg::*;
#(
    parameter int RW = 133,
    parameter int DW = 99,
    parameter int QW = 34,
    parameter int K  = 0
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [RW-1:0]        rem_in  [N_ENT],
    input  logic [QW-1:0]        q_in    [N_ENT],
    input  logic [DW-1:0]        den_in,
    input  logic [N_ENT-1:0]     neg_in,
    input  logic                 sing_in,
    output logic [RW-1:0]        rem_out [N_ENT],
    output logic [QW-1:0]        q_out   [N_ENT],
    output logic [DW-1:0]        den_out,
    output logic [N_ENT-1:0]     neg_out,
    output logic                 sing_out
);

    logic [RW-1:0] dsh;
    logic [RW-1:0] rem_next [N_ENT];
    logic [QW-1:0] q_next   [N_ENT];

    assign dsh = {{(RW-DW){1'b0}}, den_in} << K;

    always_comb
    begin
        for (int i = 0; i < N_ENT; i++)
        begin
            rem_next[i] = rem_in[i];
            q_next[i]   = q_in[i];
            if (rem_in[i] >= dsh)
            begin
                rem_next[i] = rem_in[i] - dsh;
                q_next[i][K] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= rem_next;
            q_out    <= q_next;
            den_out  <= den_in;
            neg_out  <= neg_in;
            sing_out <= sing_in;
        end
    end

endmodule

FILE: hdl/matrix_inverse_3x3.sv
// Pipelined 3x3 fixed-point matrix inverse by adjugate and exact division.
//
// The slave stream takes one matrix per word: nine signed entries, row-major,
// each WORD_BITS wide with FRAC_BITS fraction bits. The master stream gives
// one word back per matrix: the nine inverse entries in the same layout, with
// tuser carrying the singular and overflow flags.
// The stages are, in order: cofactor products, adjugate, determinant
// partials, determinant sum, magnitudes and signs, one restoring division
// stage per quotient bit (WORD_BITS + 2 of them), and saturation into the
// output register. Throughput is one matrix per cycle while the receiver
// is ready. Every stage has its own valid bit and loads whenever it is
// empty or the stage after it moves, so a stalled receiver only backs up
// the pipeline until it is full; s_axis_tready falls only when every stage
// holds a word.
// A zero determinant returns the input matrix with singular set. A quotient
// outside the signed word range saturates and sets overflow.
// Reset clears all valid bits; the data registers are not reset.
module matrix_inverse_3x3
    import mi3_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22, zero pad
    input  logic [((9*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // r_00, r_01, r_02, r_10, r_11, r_12, r_20, r_21, r_22, zero pad
    output logic [((9*WORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // singular, overflow
    output logic [1:0]           m_axis_tuser
);

`include "matrix_inverse_3x3_macros.svh"

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int AW   = 2*W + 1;
    localparam int PW   = 2*W + 1;
    localparam int DW   = 3*W + 3;
    localparam int QW   = W + 2;
    localparam int RW   = DW + QW;
    localparam int NDIV = QW;
    localparam int NST  = NDIV + 6;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    logic signed [W-1:0] m [N_ENT];

    logic signed [2*W-1:0] pa_reg [N_ENT];
    logic signed [2*W-1:0] pb_reg [N_ENT];
    logic signed [W-1:0]   m1_reg [N_ENT];
    logic signed [AW-1:0]  adj2_reg [N_ENT];
    logic signed [W-1:0]   m2_reg [N_ENT];
    logic signed [PW-1:0]  dlo_reg [3];
    logic signed [PW-1:0]  dhi_reg [3];
    logic signed [AW-1:0]  adj3_reg [N_ENT];
    logic signed [W-1:0]   m3_reg [N_ENT];
    logic signed [DW-1:0]  det_reg;
    logic signed [AW-1:0]  adj4_reg [N_ENT];
    logic signed [W-1:0]   m4_reg [N_ENT];

    logic [RW-1:0]     drem [NDIV+1][N_ENT];
    logic [QW-1:0]     dq   [NDIV+1][N_ENT];
    logic [DW-1:0]     dden [NDIV+1];
    logic [N_ENT-1:0]  dneg [NDIV+1];
    logic              dsing [NDIV+1];

    logic [RW-1:0]     rem_next [N_ENT];
    logic [QW-1:0]     q_zero   [N_ENT];
    logic [DW-1:0]     den_next;
    logic [N_ENT-1:0]  neg_next;
    logic              sing_next;
    logic signed [DW-1:0] det_next;

    logic [W-1:0]      r_reg  [N_ENT];
    logic [W-1:0]      r_next [N_ENT];
    logic              sing_reg;
    logic              ovf_reg;
    logic              ovf_next;

    genvar gi;

    // Handshake: a stage loads when it is empty or its successor moves.
    assign en[NST-1] = !v_reg[NST-1] || m_axis_tready;
    generate
        for (gi = 0; gi < NST-1; gi++)
        begin : g_en
            assign en[gi] = !v_reg[gi] || en[gi+1];
        end
    endgenerate

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_axis_tvalid;
            end
            for (int s = 1; s < NST; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    generate
        for (gi = 0; gi < N_ENT; gi++)
        begin : g_unpack
            assign m[gi] = s_axis_tdata[gi*W +: W];
        end
    endgenerate

    // Stages 1 to 4: cofactor products, adjugate, determinant partials and sum.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < N_ENT; i++)
            begin
                pa_reg[i] <= m[CF_A[i]] * m[CF_D[i]];
                pb_reg[i] <= m[CF_B[i]] * m[CF_C[i]];
            end
            m1_reg <= m;
        end
        if (en[1])
        begin
            for (int i = 0; i < N_ENT; i++)
            begin
                adj2_reg[i] <= AW'(pa_reg[i]) - AW'(pb_reg[i]);
            end
            m2_reg <= m1_reg;
        end
        if (en[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                dlo_reg[j] <= PW'(m2_reg[j])
                    * signed'({1'b0, adj2_reg[DET_ADJ[j]][W-1:0]});
                dhi_reg[j] <= PW'(m2_reg[j])
                    * PW'(signed'(adj2_reg[DET_ADJ[j]][AW-1:W]));
            end
            adj3_reg <= adj2_reg;
            m3_reg   <= m2_reg;
        end
        if (en[3])
        begin
            det_reg  <= det_next;
            adj4_reg <= adj3_reg;
            m4_reg   <= m3_reg;
        end
    end

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (DW'(dhi_reg[j]) <<< W) + DW'(dlo_reg[j]);
        end
    end

    // Stage 5: magnitudes and signs; a singular matrix divides its own bits by one.
    always_comb
    begin
        logic [AW-1:0] mag;
        sing_next = (det_reg == '0);
        den_next  = sing_next ? DW'(1)
                  : (det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg));
        for (int i = 0; i < N_ENT; i++)
        begin
            mag = adj4_reg[i][AW-1] ? AW'(-adj4_reg[i]) : AW'(adj4_reg[i]);
            q_zero[i] = '0;
            if (sing_next)
            begin
                rem_next[i] = {{(RW-W){1'b0}}, m4_reg[i]};
                neg_next[i] = 1'b0;
            end
            else
            begin
                rem_next[i] = {{(RW-AW){1'b0}}, mag} << (2*F);
                neg_next[i] = adj4_reg[i][AW-1] ^ det_reg[DW-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            drem[0]  <= rem_next;
            dq[0]    <= q_zero;
            dden[0]  <= den_next;
            dneg[0]  <= neg_next;
            dsing[0] <= sing_next;
        end
    end

    generate
        for (gi = 0; gi < NDIV; gi++)
        begin : g_div
            mi3_div_stage #(
                .RW (RW),
                .DW (DW),
                .QW (QW),
                .K  (QW - 1 - gi)
            ) u_stage (
                .clk      (clk),
                .en       (en[5+gi]),
                .rem_in   (drem[gi]),
                .q_in     (dq[gi]),
                .den_in   (dden[gi]),
                .neg_in   (dneg[gi]),
                .sing_in  (dsing[gi]),
                .rem_out  (drem[gi+1]),
                .q_out    (dq[gi+1]),
                .den_out  (dden[gi+1]),
                .neg_out  (dneg[gi+1]),
                .sing_out (dsing[gi+1])
            );
        end
    endgenerate

    // Output stage: saturate to the signed word range and restore the sign.
    always_comb
    begin
        logic [QW-1:0] lim;
        logic [QW-1:0] sat;
        ovf_next = 1'b0;
        for (int i = 0; i < N_ENT; i++)
        begin
            lim = dneg[NDIV][i] ? {3'b001, {(W-1){1'b0}}} : {3'b000, {(W-1){1'b1}}};
            sat = dq[NDIV][i];
            if (dq[NDIV][i] > lim)
            begin
                sat = lim;
                ovf_next = 1'b1;
            end
            r_next[i] = dneg[NDIV][i] ? W'(-sat[W-1:0]) : sat[W-1:0];
            if (dsing[NDIV])
            begin
                r_next[i] = dq[NDIV][i][W-1:0];
            end
        end
        if (dsing[NDIV])
        begin
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            r_reg    <= r_next;
            sing_reg <= dsing[NDIV];
            ovf_reg  <= ovf_next;
        end
    end

    always_comb
    begin
        m_axis_tdata = '0;
        for (int i = 0; i < N_ENT; i++)
        begin
            m_axis_tdata[i*W +: W] = r_reg[i];
        end
    end

    assign m_axis_tuser = {ovf_reg, sing_reg};

    `MI3_ASSERT_SAME(a_sing_no_ovf, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1])
    `MI3_ASSERT_SAME(a_full_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    `MI3_ASSERT_NEXT(a_s1_hold, v_reg[0] && !en[1], v_reg[0])

endmodule
